>>> src/assert_macros.svh
// Assertion macros shared by the tone generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dds_pkg.sv
// Shared types, constants and the sine table builder for the tone generator.
package dds_pkg;

    // Payload widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned FREQ_W   = 13;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned VOL_W    = 7;

    // Internal widths
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned LEFT_W   = 21;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned SCALE_W  = 22;
    localparam int unsigned PROD_W   = MAG_W + SCALE_W;
    localparam int unsigned NUM_W    = 13;

    // Configuration port
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned REG_SEL_BIT = 2;
    localparam logic        REG_VOLUME  = 1'b0;
    localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd100;
    localparam logic [VOL_W-1:0] VOLUME_MAX   = 7'd100;

    // Parameter defaults
    localparam int unsigned DEF_SAMPLE_RATE_HZ   = 16000;
    localparam int unsigned DEF_PEAK_AMPLITUDE   = 24000;
    localparam int unsigned DEF_SINE_TABLE_DEPTH = 1024;

    // Step = f * 2^32 / rate, by reciprocal with 29 extra fraction bits
    localparam int unsigned STEP_SHIFT  = 29;
    localparam int unsigned STEP_MUL_W  = 49;
    localparam int unsigned STEP_PROD_W = FREQ_W + STEP_MUL_W;

    // Count = rate * ms / 1000, by reciprocal with 26 fraction bits
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned CNT_SHIFT   = 26;
    localparam int unsigned CNT_MUL_W   = 32;
    localparam int unsigned CNT_PROD_W  = DUR_W + CNT_MUL_W;
    localparam int unsigned CNT_FULL_W  = CNT_PROD_W - CNT_SHIFT;

    // Divide by 100 after dropping 15 bits: ceil(2^29 / 100)
    localparam int unsigned DIV_IN_SHIFT = 15;
    localparam int unsigned DIV_IN_W     = PROD_W - DIV_IN_SHIFT;
    localparam int unsigned DIV100_W     = 23;
    localparam logic [DIV100_W-1:0] DIV100_MUL = 23'd5368710;
    localparam int unsigned DIV100_SHIFT = 29;
    localparam int unsigned DIV_PROD_W   = DIV_IN_W + DIV100_W;

    // Sine table build constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned Q15_MAX     = 64'd32767;
    localparam int unsigned     TAYLOR_N    = 12;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_N] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    // Per-stage control that travels alongside the sample data
    typedef struct packed {
        logic valid;
        logic active;
        logic last;
        logic neg;
    } t_tag;

    // round(32767 * sin(num / depth * pi/2)), Q30 Taylor series
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [NUM_W-1:0] num,
                                                      input int unsigned depth_log2);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        x    = (64'(num) * HALF_PI_Q30) >> depth_log2;
        term = x;
        sum  = x;
        for (int n = 1; n <= TAYLOR_N; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        r = (sum * Q15_MAX + (ONE_Q30 >> 1)) >> 30;
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end
        return MAG_W'(r);
    endfunction

endpackage

>>> src/dds_phase_ctrl.sv
// Note control: phase accumulator, step and sample count, table index per tick.
`include "assert_macros.svh"

module dds_phase_ctrl #(
    parameter int unsigned SAMPLE_RATE_HZ   = dds_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int unsigned SINE_TABLE_DEPTH = dds_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [dds_pkg::MODE_W-1:0]          i_mode,
    input  logic [dds_pkg::FREQ_W-1:0]          i_frequency_hz,
    input  logic [dds_pkg::DUR_W-1:0]           i_duration_ms,
    output dds_pkg::t_tag                       o_tag,
    output logic [$clog2(SINE_TABLE_DEPTH)-2:0] o_idx
);

    localparam int unsigned DepthLog2 = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned IdxW      = DepthLog2 - 1;
    localparam int unsigned Nyquist   = SAMPLE_RATE_HZ / 2;
    localparam longint unsigned StepMul =
        ((64'd1 << (dds_pkg::PHASE_W + dds_pkg::STEP_SHIFT)) + 64'(SAMPLE_RATE_HZ) - 64'd1)
        / 64'(SAMPLE_RATE_HZ);
    localparam longint unsigned CntMul =
        ((64'(SAMPLE_RATE_HZ) << dds_pkg::CNT_SHIFT) + 64'(dds_pkg::MS_PER_S) - 64'd1)
        / 64'(dds_pkg::MS_PER_S);

    logic [dds_pkg::PHASE_W-1:0]     r_phase;
    logic [dds_pkg::PHASE_W-1:0]     n_phase;
    logic [dds_pkg::PHASE_W-1:0]     r_step;
    logic [dds_pkg::PHASE_W-1:0]     n_step;
    logic [dds_pkg::LEFT_W-1:0]      r_left;
    logic [dds_pkg::LEFT_W-1:0]      n_left;
    logic                            r_running;
    logic                            n_running;
    dds_pkg::t_tag                   r_tag;
    dds_pkg::t_tag                   n_tag;
    logic [IdxW-1:0]                 r_idx;
    logic [IdxW-1:0]                 n_idx;

    logic                            accept;
    logic [DepthLog2-1:0]            phase_idx;
    logic [DepthLog2-3:0]            quad_off;
    logic [dds_pkg::FREQ_W-1:0]      freq_sat;
    logic [dds_pkg::STEP_PROD_W-1:0] step_prod;
    logic [dds_pkg::PHASE_W-1:0]     step_new;
    logic [dds_pkg::CNT_PROD_W-1:0]  cnt_prod;
    logic [dds_pkg::CNT_FULL_W-1:0]  cnt_full;
    logic [dds_pkg::LEFT_W-1:0]      cnt_sat;

    assign accept = i_valid && i_en;

    // Top bits of the phase pick the table entry; fold quadrants onto the quarter table
    assign phase_idx = r_phase[dds_pkg::PHASE_W-1 -: DepthLog2];
    assign quad_off  = phase_idx[DepthLog2-3:0];
    assign n_idx     = phase_idx[DepthLog2-2] ?
                       IdxW'(SINE_TABLE_DEPTH / 4) - IdxW'(quad_off) : IdxW'(quad_off);

    // Clamp at Nyquist, then step = floor(f * 2^32 / rate) by exact reciprocal
    assign freq_sat  = (32'(i_frequency_hz) > Nyquist) ? dds_pkg::FREQ_W'(Nyquist)
                                                        : i_frequency_hz;
    assign step_prod = dds_pkg::STEP_PROD_W'(freq_sat) * dds_pkg::STEP_PROD_W'(StepMul);
    assign step_new  = step_prod[dds_pkg::STEP_SHIFT +: dds_pkg::PHASE_W];

    // count = floor(rate * ms / 1000), saturated to the counter width
    assign cnt_prod = dds_pkg::CNT_PROD_W'(i_duration_ms) * dds_pkg::CNT_PROD_W'(CntMul);
    assign cnt_full = cnt_prod[dds_pkg::CNT_SHIFT +: dds_pkg::CNT_FULL_W];
    assign cnt_sat  = (|cnt_full[dds_pkg::CNT_FULL_W-1:dds_pkg::LEFT_W]) ?
                      {dds_pkg::LEFT_W{1'b1}} : cnt_full[dds_pkg::LEFT_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_left    = r_left;
        n_running = r_running;
        n_tag     = '0;
        if (accept) begin
            case (i_mode)
                dds_pkg::MODE_START: begin
                    n_phase   = '0;
                    n_step    = step_new;
                    n_left    = cnt_sat;
                    n_running = (cnt_sat != '0);
                end
                dds_pkg::MODE_TICK: begin
                    n_tag.valid = 1'b1;
                    if (r_running && (r_left != '0)) begin
                        n_tag.active = 1'b1;
                        n_tag.neg    = phase_idx[DepthLog2-1];
                        n_phase      = r_phase + r_step;
                        n_left       = r_left - dds_pkg::LEFT_W'(1);
                        if (r_left == dds_pkg::LEFT_W'(1)) begin
                            n_tag.last = 1'b1;
                            n_running  = 1'b0;
                        end
                    end else begin
                        n_running = 1'b0;
                    end
                end
                dds_pkg::MODE_STOP: begin
                    n_running = 1'b0;
                    n_left    = '0;
                end
                default: begin
                    // unused mode code: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_left    <= '0;
            r_running <= 1'b0;
            r_tag     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_left    <= n_left;
            r_running <= n_running;
            if (i_en) begin
                r_tag <= n_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
        end
    end

    assign o_tag = r_tag;
    assign o_idx = r_idx;

    `ASSERT_ALWAYS(a_run_has_count, i_clk, i_rst_n, r_running == (r_left != '0),
        "running flag disagrees with remaining sample count")
    `ASSERT_NEXT(a_phase_advance, i_clk, i_rst_n,
        accept && (i_mode == dds_pkg::MODE_TICK) && r_running,
        r_phase == $past(r_phase + r_step), "phase did not advance by the step")

endmodule

>>> src/dds_sine_rom.sv
// Quarter-wave Q15 sine table with registered lookup.
module dds_sine_rom #(
    parameter int unsigned SINE_TABLE_DEPTH = dds_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  dds_pkg::t_tag                       i_tag,
    input  logic [$clog2(SINE_TABLE_DEPTH)-2:0] i_idx,
    output dds_pkg::t_tag                       o_tag,
    output logic [dds_pkg::MAG_W-1:0]           o_mag
);

    localparam int unsigned DepthLog2 = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned Entries   = SINE_TABLE_DEPTH / 4 + 1;

    logic [dds_pkg::MAG_W-1:0] sine_tab [Entries];
    dds_pkg::t_tag             r_tag;
    logic [dds_pkg::MAG_W-1:0] r_mag;

    // Entry k holds the quarter sine at table position 4k
    for (genvar k = 0; k < Entries; k++) begin : g_tab
        localparam logic [dds_pkg::MAG_W-1:0] Entry =
            dds_pkg::quarter_sine(dds_pkg::NUM_W'(4 * k), DepthLog2);
        assign sine_tab[k] = Entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= sine_tab[i_idx];
        end
    end

    assign o_tag = r_tag;
    assign o_mag = r_mag;

endmodule

>>> src/dds_scaler.sv
// Amplitude scaling, divide by 3276800 and the result register.
`include "assert_macros.svh"

module dds_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  dds_pkg::t_tag                      i_tag,
    input  logic [dds_pkg::MAG_W-1:0]          i_mag,
    input  logic [dds_pkg::SCALE_W-1:0]        i_scale,
    output logic                               o_valid,
    output logic signed [dds_pkg::SAMPLE_W-1:0] o_sample_value,
    output logic                               o_note_active,
    output logic                               o_last_sample
);

    dds_pkg::t_tag                       r_ptag;
    logic [dds_pkg::PROD_W-1:0]          r_prod;
    logic                                r_out_valid;
    logic signed [dds_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_active;
    logic                                r_last;

    logic [dds_pkg::DIV_IN_W-1:0]        div_in;
    logic [dds_pkg::DIV_PROD_W-1:0]      div_prod;
    logic [dds_pkg::SAMPLE_W-1:0]        mag_q;
    logic signed [dds_pkg::SAMPLE_W-1:0] n_sample;

    // floor(x / 3276800) = floor(floor(x / 2^15) / 100), the latter by exact reciprocal
    assign div_in   = r_prod[dds_pkg::DIV_IN_SHIFT +: dds_pkg::DIV_IN_W];
    assign div_prod = dds_pkg::DIV_PROD_W'(div_in) * dds_pkg::DIV_PROD_W'(dds_pkg::DIV100_MUL);
    assign mag_q    = div_prod[dds_pkg::DIV100_SHIFT +: dds_pkg::SAMPLE_W];

    always_comb begin
        if (!r_ptag.active) begin
            n_sample = '0;
        end else if (r_ptag.neg) begin
            n_sample = $signed(dds_pkg::SAMPLE_W'(-mag_q));
        end else begin
            n_sample = $signed(mag_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_ptag      <= i_tag;
            r_out_valid <= r_ptag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= dds_pkg::PROD_W'(i_mag) * dds_pkg::PROD_W'(i_scale);
            r_sample <= n_sample;
            r_active <= r_ptag.active;
            r_last   <= r_ptag.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_sample;
    assign o_note_active  = r_active;
    assign o_last_sample  = r_last;

    `ASSERT_IMPLY(a_idle_silent, i_clk, i_rst_n, r_out_valid && !r_active,
        (r_sample == '0) && !r_last, "silent result carries a sample or last flag")

endmodule

>>> src/dds_tone_generator.sv
// A tick's result passes the control, table, product and output registers in that order.
// One transaction per cycle unless stalled; start and stop update state in their own cycle.
// A full output register that is not taken stalls the whole pipeline and drops input ready.
// Reset is synchronous, active low: silence, phase and step zero, volume 100 percent.
// No table or memory clearing after reset; the first cycle out of reset accepts items.
module dds_tone_generator #(
    parameter int unsigned SAMPLE_RATE_HZ   = dds_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int unsigned PEAK_AMPLITUDE   = dds_pkg::DEF_PEAK_AMPLITUDE,
    parameter int unsigned SINE_TABLE_DEPTH = dds_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [dds_pkg::MODE_W-1:0]           i_mode,
    input  logic [dds_pkg::FREQ_W-1:0]           i_frequency_hz,
    input  logic [dds_pkg::DUR_W-1:0]            i_duration_ms,
    // Result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dds_pkg::SAMPLE_W-1:0]  o_sample_value,
    output logic                                 o_note_active,
    output logic                                 o_last_sample,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dds_pkg::ADDR_W-1:0]           paddr,
    input  logic [dds_pkg::DATA_W-1:0]           pwdata,
    output logic [dds_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH) - 1;

    logic [dds_pkg::VOL_W-1:0]   r_volume;
    logic [dds_pkg::SCALE_W-1:0] r_scale;
    logic [dds_pkg::SCALE_W-1:0] n_scale;

    logic                        cfg_wr;
    logic [dds_pkg::VOL_W-1:0]   vol_wr;
    logic [dds_pkg::VOL_W-1:0]   vol_sat;
    logic                        pipe_en;
    dds_pkg::t_tag               tag_s1;
    dds_pkg::t_tag               tag_s2;
    logic [IdxW-1:0]             idx_s1;
    logic [dds_pkg::MAG_W-1:0]   mag_s2;
    logic                        out_valid;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[dds_pkg::REG_SEL_BIT] == dds_pkg::REG_VOLUME);
    assign vol_wr  = pwdata[dds_pkg::VOL_W-1:0];
    assign vol_sat = (vol_wr > dds_pkg::VOLUME_MAX) ? dds_pkg::VOLUME_MAX : vol_wr;
    assign n_scale = dds_pkg::SCALE_W'(PEAK_AMPLITUDE) * dds_pkg::SCALE_W'(vol_sat);
    assign prdata  = (paddr[dds_pkg::REG_SEL_BIT] == dds_pkg::REG_VOLUME) ?
                     {{(dds_pkg::DATA_W - dds_pkg::VOL_W){1'b0}}, r_volume} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= dds_pkg::VOLUME_RESET;
            r_scale  <= dds_pkg::SCALE_W'(PEAK_AMPLITUDE * 100);
        end else if (cfg_wr) begin
            r_volume <= vol_wr;
            r_scale  <= n_scale;
        end
    end

    // Advance every stage unless a finished result is held
    assign pipe_en    = !out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    dds_phase_ctrl #(
        .SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (pipe_en),
        .i_valid        (i_in_valid),
        .i_mode         (i_mode),
        .i_frequency_hz (i_frequency_hz),
        .i_duration_ms  (i_duration_ms),
        .o_tag          (tag_s1),
        .o_idx          (idx_s1)
    );

    dds_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_tag   (tag_s1),
        .i_idx   (idx_s1),
        .o_tag   (tag_s2),
        .o_mag   (mag_s2)
    );

    dds_scaler u_scaler (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (pipe_en),
        .i_tag          (tag_s2),
        .i_mag          (mag_s2),
        .i_scale        (r_scale),
        .o_valid        (out_valid),
        .o_sample_value (o_sample_value),
        .o_note_active  (o_note_active),
        .o_last_sample  (o_last_sample)
    );

    assign o_out_valid = out_valid;

endmodule

>>> tb/dds_tone_generator_tb.sv
// Self-checking DDS tone generator testbench: directed and random notes against a predictor.
module dds_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RATE     = dds_pkg::DEF_SAMPLE_RATE_HZ;
    localparam int unsigned PEAK     = dds_pkg::DEF_PEAK_AMPLITUDE;
    localparam int unsigned DEPTH    = dds_pkg::DEF_SINE_TABLE_DEPTH;
    localparam int unsigned PIPE_LAT = 3;
    localparam int unsigned SETTLE   = PIPE_LAT + 5;
    localparam longint unsigned HALF_PI_FX = 64'd1686629713;
    localparam longint unsigned UNITY_FX   = 64'd1 << 30;
    localparam longint unsigned Q15_PEAK   = 64'd32767;
    localparam longint unsigned VOL_DIV    = 64'd32768 * 64'd100;
    localparam longint unsigned COUNT_MAX  = (64'd1 << dds_pkg::LEFT_W) - 64'd1;
    localparam logic [dds_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct {
        logic [dds_pkg::MODE_W-1:0] mode;
        logic [dds_pkg::FREQ_W-1:0] freq;
        logic [dds_pkg::DUR_W-1:0]  dur;
    } t_tone_cmd;

    typedef struct {
        logic signed [dds_pkg::SAMPLE_W-1:0] sample;
        logic                                active;
        logic                                last;
    } t_tone_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [dds_pkg::MODE_W-1:0] i_mode = '0;
    logic [dds_pkg::FREQ_W-1:0] i_frequency_hz = '0;
    logic [dds_pkg::DUR_W-1:0] i_duration_ms = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [dds_pkg::SAMPLE_W-1:0] o_sample_value;
    logic o_note_active;
    logic o_last_sample;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dds_pkg::ADDR_W-1:0] paddr = '0;
    logic [dds_pkg::DATA_W-1:0] pwdata = '0;
    logic [dds_pkg::DATA_W-1:0] prdata;
    logic pready;

    // Predictor state
    logic [dds_pkg::PHASE_W-1:0] tone_phase = '0;
    logic [dds_pkg::PHASE_W-1:0] tone_step = '0;
    logic [dds_pkg::LEFT_W-1:0]  tone_left = '0;
    logic                        tone_on = 1'b0;
    logic [dds_pkg::VOL_W-1:0]   vol_set = dds_pkg::VOLUME_RESET;
    int unsigned                 sine_mag [0:DEPTH];

    t_tone_cmd cmd_q[$];
    t_tone_out pending_samples[$];
    int unsigned pushed_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned errors = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic in_fire = 1'b0;

    dds_tone_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_frequency_hz (i_frequency_hz),
        .i_duration_ms  (i_duration_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_note_active  (o_note_active),
        .o_last_sample  (o_last_sample),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // First-quadrant sine magnitude in Q15, Taylor series in Q30
    function automatic int unsigned quarter_mag(int unsigned num);
        longint unsigned ang;
        longint unsigned pw;
        longint unsigned acc;
        longint unsigned rounded;
        ang = 64'(num) * HALF_PI_FX / 64'(DEPTH);
        pw  = ang;
        acc = ang;
        for (int k = 1; k <= 12; k++) begin
            pw = (pw * ang) >> 30;
            pw = (pw * ang) >> 30;
            pw = pw / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (acc >= pw) ? acc - pw : 64'd0;
            end else begin
                acc = acc + pw;
            end
        end
        if (acc > UNITY_FX) begin
            acc = UNITY_FX;
        end
        rounded = (acc * Q15_PEAK + (UNITY_FX >> 1)) >> 30;
        if (rounded > Q15_PEAK) begin
            rounded = Q15_PEAK;
        end
        return int'(rounded);
    endfunction

    function automatic logic signed [dds_pkg::SAMPLE_W-1:0] tone_sample(
        logic [dds_pkg::PHASE_W-1:0] ph, logic [dds_pkg::VOL_W-1:0] v);
        int unsigned idx;
        int unsigned quad;
        int unsigned off;
        int unsigned num;
        longint unsigned eff;
        longint unsigned mag;
        idx  = int'((64'(ph) * 64'(DEPTH)) >> 32);
        quad = (4 * idx) / DEPTH;
        off  = (4 * idx) % DEPTH;
        num  = (quad % 2 == 1) ? DEPTH - off : off;
        eff  = (v > dds_pkg::VOLUME_MAX) ? 64'(dds_pkg::VOLUME_MAX) : 64'(v);
        mag  = 64'(sine_mag[num]) * 64'(PEAK) * eff / VOL_DIV;
        return (quad >= 2) ? -dds_pkg::SAMPLE_W'(mag) : dds_pkg::SAMPLE_W'(mag);
    endfunction

    // Update the tone state for one accepted transaction, queue the sample a tick gives
    task automatic advance_tone(logic [dds_pkg::MODE_W-1:0] m, logic [dds_pkg::FREQ_W-1:0] f,
                                logic [dds_pkg::DUR_W-1:0] d);
        logic [dds_pkg::FREQ_W-1:0] fc;
        longint unsigned cnt;
        t_tone_out r;
        case (m)
            dds_pkg::MODE_START: begin
                fc = (f > RATE / 2) ? dds_pkg::FREQ_W'(RATE / 2) : f;
                tone_phase = '0;
                tone_step = dds_pkg::PHASE_W'((64'(fc) << 32) / 64'(RATE));
                cnt = 64'(RATE) * 64'(d) / 64'(dds_pkg::MS_PER_S);
                if (cnt > COUNT_MAX) begin
                    cnt = COUNT_MAX;
                end
                tone_left = dds_pkg::LEFT_W'(cnt);
                tone_on = (cnt != 0);
            end
            dds_pkg::MODE_STOP: begin
                tone_on = 1'b0;
                tone_left = '0;
            end
            dds_pkg::MODE_TICK: begin
                if (!tone_on || tone_left == 0) begin
                    tone_on = 1'b0;
                    r.sample = '0;
                    r.active = 1'b0;
                    r.last = 1'b0;
                end else begin
                    r.sample = tone_sample(tone_phase, vol_set);
                    tone_phase = tone_phase + tone_step;
                    tone_left = tone_left - 1'b1;
                    r.active = 1'b1;
                    r.last = (tone_left == 0);
                    if (r.last) begin
                        tone_on = 1'b0;
                    end
                end
                pending_samples.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Predict on accepted transactions, check results against the oldest prediction
    always @(posedge i_clk) begin
        t_tone_out want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= (i_in_valid && o_in_ready === 1'b1);
            if (i_in_valid && o_in_ready === 1'b1) begin
                advance_tone(i_mode, i_frequency_hz, i_duration_ms);
                accepted_cnt++;
            end
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_samples.size() == 0) begin
                    $display("%0t: unexpected result: sample %0d active %0b last %0b",
                             $time, o_sample_value, o_note_active, o_last_sample);
                    errors++;
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample_value !== want.sample) begin
                        $display("%0t: sample_value mismatch: expected %0d, actual %0d",
                                 $time, want.sample, o_sample_value);
                        errors++;
                    end
                    if (o_note_active !== want.active) begin
                        $display("%0t: note_active mismatch: expected %0b, actual %0b",
                                 $time, want.active, o_note_active);
                        errors++;
                    end
                    if (o_last_sample !== want.last) begin
                        $display("%0t: last_sample mismatch: expected %0b, actual %0b",
                                 $time, want.last, o_last_sample);
                        errors++;
                    end
                end
            end
        end
    end

    // Drive the input channel from the command queue, hold a transaction until accepted
    always @(negedge i_clk) begin
        t_tone_cmd cur;
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur = cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= cur.mode;
                    i_frequency_hz <= cur.freq;
                    i_duration_ms <= cur.dur;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_cmd(logic [dds_pkg::MODE_W-1:0] m, int unsigned f, int unsigned d);
        t_tone_cmd c;
        c.mode = m;
        c.freq = dds_pkg::FREQ_W'(f);
        c.dur = dds_pkg::DUR_W'(d);
        cmd_q.push_back(c);
        pushed_cnt++;
    endtask

    task automatic push_filler(logic [dds_pkg::MODE_W-1:0] m);
        push_cmd(m, $urandom_range(8191), $urandom_range(65535));
    endtask

    function automatic int unsigned pick_freq();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 10) return RATE / 2;
        if (r < 18) return $urandom_range(8191, RATE / 2 + 1);
        if (r < 25) return $urandom_range(50, 1);
        return $urandom_range(RATE / 2, 1);
    endfunction

    function automatic int unsigned pick_dur();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(3, 1);
        if (r < 88) return 0;
        if (r < 94) return $urandom_range(8, 4);
        return $urandom_range(65535);
    endfunction

    // Mostly complete notes with random content, some cut short, plus noise
    task automatic gen_random(int unsigned quota);
        int unsigned made;
        int unsigned d;
        int unsigned n;
        int unsigned cut;
        logic [dds_pkg::MODE_W-1:0] m;
        made = 0;
        while (made < quota) begin
            if ($urandom_range(99) < 12) begin
                m = dds_pkg::MODE_W'($urandom_range(3));
                push_filler(m);
                if (m != MODE_RESERVED) made++;
            end else begin
                d = pick_dur();
                push_cmd(dds_pkg::MODE_START, pick_freq(), d);
                made++;
                if (d == 0) begin
                    n = $urandom_range(4, 1);
                end else if (d <= 8) begin
                    n = RATE / dds_pkg::MS_PER_S * d + $urandom_range(3);
                end else begin
                    n = $urandom_range(40, 5);
                end
                cut = ($urandom_range(99) < 20) ? $urandom_range(n, 1) : n;
                repeat (cut) begin
                    push_filler(dds_pkg::MODE_TICK);
                    made++;
                end
                if ((cut < n || d > 8) && $urandom_range(1) == 1) begin
                    push_filler(dds_pkg::MODE_STOP);
                    made++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (!(accepted_cnt == pushed_cnt && pending_samples.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_volume(int unsigned v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {dds_pkg::REG_VOLUME, 2'b00};
        pwdata <= dds_pkg::DATA_W'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        vol_set = dds_pkg::VOL_W'(v);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        int unsigned vols [7] = '{0, 100, 127, 1, 50, 101, 73};
        for (int k = 0; k <= DEPTH / 4; k++) begin
            sine_mag[k] = quarter_mag(k * 4);
        end
        // Only num in 0..DEPTH is used; index directly by num
        for (int k = 0; k <= DEPTH; k++) begin
            sine_mag[k] = quarter_mag(k);
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle ticks, zero duration, saturated frequency, replace, note end
        push_filler(dds_pkg::MODE_TICK);
        push_cmd(dds_pkg::MODE_START, 0, 0);
        push_filler(dds_pkg::MODE_TICK);
        push_cmd(dds_pkg::MODE_START, 8191, 65535);
        push_filler(dds_pkg::MODE_TICK);
        push_filler(dds_pkg::MODE_TICK);
        push_filler(MODE_RESERVED);
        push_cmd(dds_pkg::MODE_START, 1000, 1);
        repeat (RATE / dds_pkg::MS_PER_S) push_filler(dds_pkg::MODE_TICK);
        push_filler(dds_pkg::MODE_TICK);
        push_filler(dds_pkg::MODE_STOP);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            write_volume(vols[p]);
            if (p == 2) begin
                // Hold the sender mid-phase until every sample is back
                gen_random(80);
                wait_drained();
                gen_random(80);
            end else begin
                gen_random(160);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("dds_tone_generator regression: pass");
        end else begin
            $display("dds_tone_generator regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("dds_tone_generator regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/dds_pkg.sv
src/dds_phase_ctrl.sv
src/dds_sine_rom.sv
src/dds_scaler.sv
src/dds_tone_generator.sv
tb/dds_tone_generator_tb.sv
